/* rtl/assc_pkg.sv */
// Shared types, constants and register indexes for the adaptive sign speed controller.
package assc_pkg;

    localparam int SPEED_W    = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int MUL_W      = 16;
    localparam int MUL_CNT_W  = $clog2(MUL_W);

    localparam logic [15:0] Q15_ONE = 16'h8000;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_WEIGHT   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BIAS_THR = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BIAS_STP = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_THR = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_STP = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_DRV  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_DRV  = 3'd6;

    // reset values
    localparam logic [15:0] RST_WEIGHT   = 16'd29491;
    localparam logic [15:0] RST_BIAS_THR = 16'd16384;
    localparam logic [15:0] RST_BIAS_STP = 16'd33;
    localparam logic [15:0] RST_GAIN_THR = 16'd16384;
    localparam logic [15:0] RST_GAIN_STP = 16'd33;
    localparam logic [15:0] RST_MIN_DRV  = 16'h8000;
    localparam logic [15:0] RST_MAX_DRV  = 16'h7FFF;

    typedef struct packed {
        logic signed [SPEED_W-1:0] measured_speed;
        logic signed [SPEED_W-1:0] target_speed;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] drive;
        logic        [15:0] effort;
    } t_out_item;

    typedef struct packed {
        logic        [15:0] weight;     // already limited to 1.0
        logic        [15:0] bias_thr;
        logic        [15:0] bias_step;
        logic        [15:0] gain_thr;
        logic        [15:0] gain_step;
        logic signed [15:0] min_drive;
        logic signed [15:0] max_drive;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic               done;
        logic [2*MUL_W-1:0] prod;
    } t_mul_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_FS,
        ST_ADAPT,
        ST_EFFORT,
        ST_DRV_GO,
        ST_MUL_DRV,
        ST_OUT
    } t_state;

endpackage

/* rtl/adaptive_sign_speed_controller_top.sv */
// Top level of the adaptive sign speed controller: wiring and result register.
//
// Usage:
//  - Input channel (i_in_valid / o_in_ready / i_in_data) carries one transaction
//    per control sample: measured and target speed, signed.
//  - Output channel (o_out_valid / i_out_ready / o_out_data) returns exactly one
//    transaction per input: the scaled drive and the clamped Q1.15 effort.
//  - Configuration is a plain write port (i_cfg_we, i_cfg_addr, i_cfg_wdata);
//    write only while no transaction is in flight. Unmapped indexes are dropped.
//  - Both products (filter weight times filtered sign, effort times drive
//    limit) go through one bit-serial multiplier at one bit per cycle. The
//    filter product starts on input acceptance; the adapt, effort and
//    multiplier start states follow it, then the drive product, and the result
//    moves into the output register. The sequencer takes no new input until it
//    is back in idle, so one transaction is in flight at a time.
//  - The next input is taken as soon as the result has moved into the output
//    register. While the receiver stalls, the output register holds one result
//    and the next one waits in the sequencer with o_in_ready low.
//  - Reset (i_rst_n low, synchronous) restores the register defaults and
//    clears the filtered sign, bias and gain levels to zero.
module adaptive_sign_speed_controller_top import assc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data
);

    t_cfg      cfg;
    t_mul_req  mul_req;
    t_mul_rsp  mul_rsp;
    logic      res_valid;
    logic      res_ready;
    t_out_item res_data;

    logic      r_out_valid;
    t_out_item r_out_data;

    assc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    assc_serial_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    assc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_mul_req   (mul_req),
        .i_mul_rsp   (mul_rsp),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res_data  (res_data)
    );

    // output register: load when empty or being drained this cycle
    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid)
            r_out_data <= res_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef NO_ASSERTIONS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("output transaction changed while stalled");
    a_no_accept_while_result_pending: assert property (@(posedge i_clk)
        disable iff (!i_rst_n)
        (res_valid && !res_ready) |-> !o_in_ready)
        else $error("input taken while a result waits for the output register");
    a_effort_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.effort <= Q15_ONE))
        else $error("effort above 1.0");
`endif

endmodule

/* rtl/assc_cfg_regs.sv */
// Configuration register file with write decode and weight limiting.
module assc_cfg_regs import assc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                  o_cfg
);

    logic [15:0] r_weight, r_bias_thr, r_bias_stp, r_gain_thr, r_gain_stp;
    logic [15:0] r_min_drv, r_max_drv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight   <= RST_WEIGHT;
            r_bias_thr <= RST_BIAS_THR;
            r_bias_stp <= RST_BIAS_STP;
            r_gain_thr <= RST_GAIN_THR;
            r_gain_stp <= RST_GAIN_STP;
            r_min_drv  <= RST_MIN_DRV;
            r_max_drv  <= RST_MAX_DRV;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_WEIGHT:   r_weight   <= i_cfg_wdata;
                REG_BIAS_THR: r_bias_thr <= i_cfg_wdata;
                REG_BIAS_STP: r_bias_stp <= i_cfg_wdata;
                REG_GAIN_THR: r_gain_thr <= i_cfg_wdata;
                REG_GAIN_STP: r_gain_stp <= i_cfg_wdata;
                REG_MIN_DRV:  r_min_drv  <= i_cfg_wdata;
                REG_MAX_DRV:  r_max_drv  <= i_cfg_wdata;
                default: ;   // unmapped index, dropped
            endcase
        end
    end

    always_comb begin
        o_cfg.weight    = (r_weight > Q15_ONE) ? Q15_ONE : r_weight;
        o_cfg.bias_thr  = r_bias_thr;
        o_cfg.bias_step = r_bias_stp;
        o_cfg.gain_thr  = r_gain_thr;
        o_cfg.gain_step = r_gain_stp;
        o_cfg.min_drive = $signed(r_min_drv);
        o_cfg.max_drive = $signed(r_max_drv);
    end

endmodule

/* rtl/assc_serial_mul.sv */
// Bit-serial shift-add multiplier for unsigned magnitudes, one multiplier bit per cycle.
module assc_serial_mul import assc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    logic [2*MUL_W-1:0] r_acc, n_acc;
    logic [MUL_W-1:0]   r_a;
    logic [MUL_W-1:0]   r_b;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [MUL_W:0]     sum;

    // add the multiplicand into the top half, then shift everything right
    assign sum   = {1'b0, r_acc[2*MUL_W-1:MUL_W]} + (r_b[0] ? {1'b0, r_a} : '0);
    assign n_acc = {sum, r_acc[MUL_W-1:1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == MUL_CNT_W'(MUL_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= '0;
            r_a   <= i_req.a;
            r_b   <= i_req.b;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_b   <= r_b >> 1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_acc;

`ifndef NO_ASSERTIONS
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("multiplier done without a running product");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_req.start)
        else $error("multiplier restarted while busy");
    a_done_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("multiplier done held longer than one cycle");
`endif

endmodule

/* rtl/assc_ctrl.sv */
// Sequencer and narrow datapath: sign filter, bias/gain adaptation, effort and drive.
module assc_ctrl import assc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output t_mul_req  o_mul_req,
    input  t_mul_rsp  i_mul_rsp,
    output logic      o_res_valid,
    input  logic      i_res_ready,
    output t_out_item o_res_data
);

    localparam logic signed [17:0] ONE18 = 18'sd32768;

    t_state r_state, n_state;

    logic signed [16:0] r_fs;
    logic [15:0]        r_bias, r_gain, r_eff;
    logic signed [15:0] r_drive;
    logic               r_gt, r_lt, r_tpos, r_tneg;

    logic               accept;
    logic               fs_neg;
    logic [15:0]        fs_mag, prod_q, off;
    logic signed [17:0] q_s, fs_sum, fs18;
    logic signed [16:0] fs_next;
    logic signed [17:0] bias_sum, gain_sum, eff_sum;
    logic signed [15:0] scale;
    logic               sc_neg;
    logic [15:0]        sc_mag;
    logic signed [15:0] drive_next;

    function automatic logic [15:0] clamp_q15(input logic signed [17:0] v);
        if (v < 18'sd0)
            clamp_q15 = '0;
        else if (v > ONE18)
            clamp_q15 = Q15_ONE;
        else
            clamp_q15 = v[15:0];
    endfunction

    assign accept = i_in_valid && o_in_ready;

    // sign filter: trunc(w*fs) computed on magnitudes, sign restored afterwards
    always_comb begin
        fs_neg = r_fs[16];
        fs_mag = fs_neg ? 16'(-r_fs) : r_fs[15:0];
        prod_q = i_mul_rsp.prod[30:15];
        off    = Q15_ONE - i_cfg.weight;
        q_s    = fs_neg ? -$signed({2'b00, prod_q}) : $signed({2'b00, prod_q});
        fs_sum = r_gt ? q_s + $signed({2'b00, off}) : q_s - $signed({2'b00, off});
        if (fs_sum > ONE18)
            fs_next = 17'sd32768;
        else if (fs_sum < -ONE18)
            fs_next = -17'sd32768;
        else
            fs_next = fs_sum[16:0];
    end

    // bias and gain stepping from the filtered sign
    always_comb begin
        fs18 = {r_fs[16], r_fs};
        bias_sum = $signed({2'b00, r_bias});
        if (fs18 > $signed({2'b00, i_cfg.bias_thr}))
            bias_sum = $signed({2'b00, r_bias}) + $signed({2'b00, i_cfg.bias_step});
        else if (fs18 < -$signed({2'b00, i_cfg.bias_thr}))
            bias_sum = $signed({2'b00, r_bias}) - $signed({2'b00, i_cfg.bias_step});
        if (fs_mag > i_cfg.gain_thr)
            gain_sum = $signed({2'b00, r_gain}) + $signed({2'b00, i_cfg.gain_step});
        else
            gain_sum = $signed({2'b00, r_gain}) - $signed({2'b00, i_cfg.gain_step});
    end

    always_comb begin
        if (r_gt)
            eff_sum = $signed({2'b00, r_bias}) + $signed({2'b00, r_gain});
        else if (r_lt)
            eff_sum = $signed({2'b00, r_bias}) - $signed({2'b00, r_gain});
        else
            eff_sum = $signed({2'b00, r_bias});
    end

    // drive scale and saturation; only +1.0 overflows
    always_comb begin
        if (r_tpos)
            scale = i_cfg.max_drive;
        else if (r_tneg)
            scale = i_cfg.min_drive;
        else
            scale = '0;
        sc_neg = scale[15];
        sc_mag = sc_neg ? 16'(-scale) : scale;
        if (sc_neg)
            drive_next = $signed(16'(-prod_q));
        else if (prod_q[15])
            drive_next = 16'sh7FFF;
        else
            drive_next = $signed(prod_q);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:    if (i_in_valid) n_state = ST_MUL_FS;
            ST_MUL_FS:  if (i_mul_rsp.done) n_state = ST_ADAPT;
            ST_ADAPT:   n_state = ST_EFFORT;
            ST_EFFORT:  n_state = ST_DRV_GO;
            ST_DRV_GO:  n_state = ST_MUL_DRV;
            ST_MUL_DRV: if (i_mul_rsp.done) n_state = ST_OUT;
            ST_OUT:     if (i_res_ready) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready      = 1'b0;
        o_res_valid     = 1'b0;
        o_mul_req.start = 1'b0;
        o_mul_req.a     = r_eff;
        o_mul_req.b     = sc_mag;
        case (r_state)
            ST_IDLE: begin
                o_in_ready      = 1'b1;
                o_mul_req.start = i_in_valid;
                o_mul_req.a     = i_cfg.weight;
                o_mul_req.b     = fs_mag;
            end
            ST_DRV_GO: o_mul_req.start = 1'b1;
            ST_OUT:    o_res_valid     = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fs    <= '0;
            r_bias  <= '0;
            r_gain  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_MUL_FS && i_mul_rsp.done)
                r_fs <= fs_next;
            if (r_state == ST_ADAPT) begin
                r_bias <= clamp_q15(bias_sum);
                r_gain <= clamp_q15(gain_sum);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_gt   <= i_in_data.measured_speed > i_in_data.target_speed;
            r_lt   <= i_in_data.measured_speed < i_in_data.target_speed;
            r_tpos <= i_in_data.target_speed > 0;
            r_tneg <= i_in_data.target_speed < 0;
        end
        if (r_state == ST_EFFORT)
            r_eff <= clamp_q15(eff_sum);
        if (r_state == ST_MUL_DRV && i_mul_rsp.done)
            r_drive <= drive_next;
    end

    assign o_res_data.drive  = r_drive;
    assign o_res_data.effort = r_eff;

`ifndef NO_ASSERTIONS
    a_levels_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bias <= Q15_ONE) && (r_gain <= Q15_ONE))
        else $error("bias or gain level outside 0..1");
    a_fs_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fs <= 17'sd32768) && (r_fs >= -17'sd32768))
        else $error("filtered sign outside -1..1");
    a_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_mul_rsp.done |-> (r_state == ST_MUL_FS || r_state == ST_MUL_DRV))
        else $error("product finished outside a multiply state");
    a_accept_starts_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> o_mul_req.start ##1 (r_state == ST_MUL_FS))
        else $error("accepted transaction did not start the filter product");
`endif

endmodule

/* bench/assc_drive_checker.sv */
// Scoreboard for the speed controller: predicts drive and effort per speed sample and compares.
module assc_drive_checker import assc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in_item              i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_out_item             i_out_data,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked
);

    localparam int     NUM_REGS     = int'(REG_MAX_DRV) + 1;
    localparam longint ONE          = 32768;
    localparam longint DRV_MIN      = -32768;
    localparam longint DRV_MAX      = 32767;
    localparam int     REPORT_LIMIT = 10;

    // shadow copy of the register file and of the adaptive state
    logic [15:0] reg_shadow [0:NUM_REGS-1];
    longint      filt_sign;
    longint      bias_lv;
    longint      gain_lv;

    t_out_item   drive_effort_q [$];
    t_out_item   want;
    int          fails;
    int          checked;

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // advances the filtered sign, bias and gain, then forms effort and drive
    function automatic t_out_item predict_drive_effort(input t_in_item smp);
        longint    cur;
        longint    tgt;
        longint    w;
        longint    fs;
        longint    thr;
        longint    mag;
        longint    lvl;
        longint    eff;
        longint    scale;
        t_out_item res;
        cur = longint'(smp.measured_speed);
        tgt = longint'(smp.target_speed);
        w   = longint'(reg_shadow[REG_WEIGHT]);
        if (w > ONE) w = ONE;

        fs = (w * filt_sign) / ONE;
        if (cur > tgt) fs = fs + (ONE - w);
        else fs = fs - (ONE - w);
        fs = clip(fs, -ONE, ONE);
        filt_sign = fs;

        thr = longint'(reg_shadow[REG_BIAS_THR]);
        lvl = bias_lv;
        if (fs > thr) lvl = lvl + longint'(reg_shadow[REG_BIAS_STP]);
        else if (fs < -thr) lvl = lvl - longint'(reg_shadow[REG_BIAS_STP]);
        bias_lv = clip(lvl, 0, ONE);

        mag = (fs < 0) ? -fs : fs;
        lvl = gain_lv;
        if (mag > longint'(reg_shadow[REG_GAIN_THR])) lvl = lvl + longint'(reg_shadow[REG_GAIN_STP]);
        else lvl = lvl - longint'(reg_shadow[REG_GAIN_STP]);
        gain_lv = clip(lvl, 0, ONE);

        if (cur > tgt) eff = bias_lv + gain_lv;
        else if (cur < tgt) eff = bias_lv - gain_lv;
        else eff = bias_lv;
        eff = clip(eff, 0, ONE);

        if (tgt > 0) scale = longint'($signed(reg_shadow[REG_MAX_DRV]));
        else if (tgt < 0) scale = longint'($signed(reg_shadow[REG_MIN_DRV]));
        else scale = 0;

        res.drive  = 16'(clip((eff * scale) / ONE, DRV_MIN, DRV_MAX));
        res.effort = 16'(eff);
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reg_shadow[REG_WEIGHT]   = RST_WEIGHT;
            reg_shadow[REG_BIAS_THR] = RST_BIAS_THR;
            reg_shadow[REG_BIAS_STP] = RST_BIAS_STP;
            reg_shadow[REG_GAIN_THR] = RST_GAIN_THR;
            reg_shadow[REG_GAIN_STP] = RST_GAIN_STP;
            reg_shadow[REG_MIN_DRV]  = RST_MIN_DRV;
            reg_shadow[REG_MAX_DRV]  = RST_MAX_DRV;
            filt_sign = 0;
            bias_lv   = 0;
            gain_lv   = 0;
            drive_effort_q.delete();
        end else begin
            // unmapped indexes are dropped by the block
            if (i_cfg_we && i_cfg_addr <= REG_MAX_DRV) reg_shadow[i_cfg_addr] = i_cfg_wdata;

            if (i_in_valid && i_in_ready) drive_effort_q.push_back(predict_drive_effort(i_in_data));

            if (i_out_valid && i_out_ready) begin
                if (drive_effort_q.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_LIMIT)
                        $display("ERROR: unexpected result drive=%0d effort=%0d",
                                 i_out_data.drive, i_out_data.effort);
                end else begin
                    want = drive_effort_q.pop_front();
                    checked++;
                    if (i_out_data.drive !== want.drive || i_out_data.effort !== want.effort) begin
                        fails++;
                        if (fails <= REPORT_LIMIT)
                            $display("ERROR: result %0d: drive exp %0d got %0d, effort exp %0d got %0d",
                                     checked, want.drive, i_out_data.drive,
                                     want.effort, i_out_data.effort);
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= drive_effort_q.size();
        o_checked    <= checked;
    end

endmodule

/* bench/tb_top.sv */
// Testbench top: clock, reset, speed sample stimulus, register programming and verdict.
module tb_top;
    import assc_pkg::*;

    localparam int NUM_REGS        = int'(REG_MAX_DRV) + 1;
    localparam int RESET_CYCLES    = 12;
    localparam int IDLE_PCT        = 23;     // percent of cycles the receiver sits idle
    localparam int GAP_PCT         = 30;     // chance of a sender gap before a transaction
    localparam int GAP_MAX         = 45;
    localparam int HOLD_CYCLES     = 500;    // receiver hold-off, fills the block
    localparam int RAND_PHASES     = 7;
    localparam int ITEMS_PER_PHASE = 90;
    localparam int CALM_PHASE      = 3;      // no idling on either side
    localparam int HOLD_PHASE      = 1;
    localparam int TAIL_CYCLES     = 60;
    localparam int SPD_MIN         = -32768;
    localparam int SPD_MAX         = 32767;
    localparam int WATCHDOG_TIME   = 4_000_000;

    // the only index the 3-bit port can reach that maps to nothing
    localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED = 3'd7;

    typedef enum logic [1:0] {
        RUN_ABOVE,      // measured above target for the whole run
        RUN_BELOW,
        RUN_EQUAL,
        RUN_NOISE       // measured speed fully random
    } t_run_kind;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in_item              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_data;

    int fail_count;
    int pending;
    int checked;

    // shared between the stimulus and the receiver process
    bit calm    = 1'b0;
    bit rx_hold = 1'b0;

    logic [15:0] next_regs [0:NUM_REGS-1];
    int          items_sent   = 0;
    int          settings_cnt = 0;

    adaptive_sign_speed_controller_top DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    assc_drive_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_addr   (cfg_addr),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offer one speed sample and hold it until the block takes it. Valid is only
    // lowered when a gap is inserted, so back-to-back transactions keep it high.
    task automatic send_speeds(input int cur, input int tgt);
        if (!calm && $urandom_range(0, 99) < GAP_PCT) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, GAP_MAX)) @(posedge clk);
        end
        in_valid                <= 1'b1;
        in_data.measured_speed  <= 16'(cur);
        in_data.target_speed    <= 16'(tgt);
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    // Stop offering, then wait until every predicted result has been taken;
    // each sample yields exactly one result, so an empty scoreboard means idle.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        @(posedge clk);
    endtask

    // Writes every register from next_regs in index order, optionally followed
    // by a write to the unmapped index that the block must drop.
    task automatic program_regs(input bit with_unmapped);
        int idx;
        for (idx = int'(REG_WEIGHT); idx <= int'(REG_MAX_DRV); idx++) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= CFG_ADDR_W'(idx);
            cfg_wdata <= next_regs[idx];
            @(posedge clk);
        end
        if (with_unmapped) begin
            cfg_addr  <= REG_UNMAPPED;
            cfg_wdata <= 16'($urandom);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_cnt++;
    endtask

    function automatic logic [15:0] pick_level(input int typ_max);
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return Q15_ONE;
            2:       return 16'hFFFF;
            3, 4:    return 16'($urandom);
            default: return 16'($urandom_range(0, typ_max));
        endcase
    endfunction

    function automatic logic [15:0] pick_limit();
        case ($urandom_range(0, 6))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int pick_target();
        case ($urandom_range(0, 9))
            0, 1:    return 0;
            2:       return SPD_MIN;
            3:       return SPD_MAX;
            default: return int'($signed(16'($urandom)));
        endcase
    endfunction

    // Random register set: weight mostly near one so the sign filter behaves like
    // a real loop, thresholds across the full range, steps mostly modest.
    task automatic roll_settings();
        if ($urandom_range(0, 1)) next_regs[REG_WEIGHT] = 16'($urandom_range(20000, 32768));
        else next_regs[REG_WEIGHT] = pick_level(32768);
        next_regs[REG_BIAS_THR] = pick_level(32768);
        next_regs[REG_BIAS_STP] = pick_level(3000);
        next_regs[REG_GAIN_THR] = pick_level(32768);
        next_regs[REG_GAIN_STP] = pick_level(3000);
        next_regs[REG_MIN_DRV]  = pick_limit();
        next_regs[REG_MAX_DRV]  = pick_limit();
    endtask

    // A run of samples with the same error sign drives the filtered sign toward
    // its rails, which is what moves bias and gain through their thresholds.
    task automatic send_run(input t_run_kind kind, input int len);
        int n;
        int cur;
        int tgt;
        int delta;
        for (n = 0; n < len; n++) begin
            tgt   = pick_target();
            delta = $urandom_range(0, 1) ? $urandom_range(1, 64) : $urandom_range(1, 65535);
            case (kind)
                RUN_ABOVE: begin
                    if (tgt == SPD_MAX) tgt = SPD_MAX - 1;
                    cur = tgt + delta;
                    if (cur > SPD_MAX) cur = SPD_MAX;
                end
                RUN_BELOW: begin
                    if (tgt == SPD_MIN) tgt = SPD_MIN + 1;
                    cur = tgt - delta;
                    if (cur < SPD_MIN) cur = SPD_MIN;
                end
                RUN_EQUAL: cur = tgt;
                default:   cur = int'($signed(16'($urandom)));
            endcase
            send_speeds(cur, tgt);
        end
    endtask

    // Receiver: random ready, always ready in the calm phase, and one long
    // hold-off counted here so the block backs up and drops o_in_ready.
    initial begin : rx_side
        int held;
        forever begin
            @(posedge clk);
            if (rx_hold) begin
                out_ready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
                rx_hold = 1'b0;
            end else if (calm) begin
                out_ready <= 1'b1;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    initial begin : stimulus
        int        ph;
        int        phase_items;
        int        pick;
        int        len;
        bit        hold_done;
        t_run_kind kind;
        hold_done = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed: reset register values ---
        // speed extremes both ways, equal speeds, zero targets of either sign of error
        send_speeds(SPD_MAX, SPD_MIN);
        send_speeds(SPD_MIN, SPD_MAX);
        send_speeds(0, 0);
        send_speeds(5, 5);
        send_speeds(-7, -7);
        send_speeds(SPD_MIN, SPD_MIN);
        send_speeds(SPD_MAX, SPD_MAX);
        send_speeds(100, 0);
        send_speeds(-100, 0);
        drain();

        // --- directed: zero weight, zero thresholds, oversized steps ---
        // filtered sign jumps to a rail every sample, bias and gain slam to
        // their clamps, and a full effort on the most negative limit gives the full negative drive
        next_regs[REG_WEIGHT]   = 16'd0;
        next_regs[REG_BIAS_THR] = 16'd0;
        next_regs[REG_BIAS_STP] = 16'hFFFF;
        next_regs[REG_GAIN_THR] = 16'd0;
        next_regs[REG_GAIN_STP] = 16'hFFFF;
        next_regs[REG_MIN_DRV]  = 16'h8000;
        next_regs[REG_MAX_DRV]  = 16'h7FFF;
        program_regs(1'b1);
        send_speeds(10, -5);
        send_speeds(10, 20);
        send_speeds(20, 20);
        send_speeds(-3, 4);
        send_speeds(300, 1);
        drain();

        // --- directed: weight above one, thresholds that never fire ---
        // the filtered sign freezes at its rail, gain only decays, limits swapped
        next_regs[REG_WEIGHT]   = 16'hFFFF;
        next_regs[REG_BIAS_THR] = 16'hFFFF;
        next_regs[REG_BIAS_STP] = Q15_ONE;
        next_regs[REG_GAIN_THR] = 16'hFFFF;
        next_regs[REG_GAIN_STP] = Q15_ONE;
        next_regs[REG_MIN_DRV]  = 16'h7FFF;
        next_regs[REG_MAX_DRV]  = 16'h8000;
        program_regs(1'b0);
        send_speeds(9, 1);
        send_speeds(-9, -1);
        send_speeds(4, 4);
        send_speeds(1, 2);
        drain();

        // --- random phases, each under its own register set ---
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            roll_settings();
            program_regs(ph % 2 == 0);
            calm        = (ph == CALM_PHASE);
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE) begin
                // start the receiver hold-off part way in; the sender keeps going
                if (ph == HOLD_PHASE && phase_items >= 30 && !hold_done) begin
                    rx_hold   = 1'b1;
                    hold_done = 1'b1;
                end
                pick = $urandom_range(0, 9);
                if (pick < 4) kind = RUN_ABOVE;
                else if (pick < 8) kind = RUN_BELOW;
                else if (pick == 8) kind = RUN_EQUAL;
                else kind = RUN_NOISE;
                len = $urandom_range(1, 24);
                send_run(kind, len);
                phase_items += len;
            end
            drain();
            calm = 1'b0;
        end

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Summary: %0d speed samples over %0d register settings, %0d compared.",
                 items_sent, settings_cnt, checked);
        $display("Summary: rails, equal and zero targets, a %0d-cycle stall, unmapped writes.",
                 HOLD_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // hard stop if the handshakes hang
    initial begin : watchdog
        #(WATCHDOG_TIME);
        $display("Test completed with failures");
        $finish;
    end

endmodule
